@@ rtl/vctg_pkg.sv @@
`default_nettype none

package vctg_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ON_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FREQ_OFFSET  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FREQ_SPAN    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_SPAN  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TICK_RATE    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_HALF    = 3'd5;
    localparam int CFG_DATA_BITS = 16;

    // Register defaults
    localparam logic [9:0]  RST_ON_THRESHOLD = 10'd172;
    localparam logic [9:0]  RST_FREQ_OFFSET  = 10'd50;
    localparam logic [9:0]  RST_FREQ_SPAN    = 10'd575;
    localparam logic [9:0]  RST_SAMPLE_SPAN  = 10'd851;
    localparam logic [15:0] RST_TICK_RATE    = 16'd10000;
    localparam logic [15:0] RST_IDLE_HALF    = 16'd500;

    // Datapath limits and pin patterns
    localparam logic [9:0]  FREQ_MAX   = 10'd1023;
    localparam logic [15:0] HALF_MAX   = 16'hFFFF;
    localparam logic [1:0]  PINS_RESET = 2'b01;
    localparam logic [1:0]  PINS_FLIP  = 2'b11;

    // Divider denominator width: twice a 10-bit frequency
    localparam int DEN_BITS = 11;

    // Request opcodes after classification
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [9:0]  on_threshold;
        logic [9:0]  freq_offset;
        logic [9:0]  freq_span;
        logic [9:0]  sample_span;
        logic [15:0] tick_rate;
        logic [15:0] idle_half_period;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic op;
    } queue_head_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/vctg_if.sv @@
`default_nettype none

// Input request channel
interface vctg_item_if #(parameter int SAMPLE_BITS = 10) ();
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// Result channel
interface vctg_result_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  pins;
    logic        enabled;
    logic [15:0] half_period;
    logic [9:0]  frequency;

    modport source (output valid, output pins, output enabled, output half_period,
                    output frequency, input ready);
    modport sink   (input valid, input pins, input enabled, input half_period,
                    input frequency, output ready);
endinterface

// Register write channel
interface vctg_cfg_if ();
    logic                                valid;
    logic                                ready;
    logic [vctg_pkg::CFG_INDEX_BITS-1:0] index;
    logic [vctg_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/vctg_front.sv @@
`default_nettype none

module vctg_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    vctg_item_if.sink                     item,
    input  wire logic                     pop,
    output vctg_pkg::queue_head_t         head,
    output logic [SAMPLE_BITS-1:0]        head_sample
);

    logic                   op_reg     [2];
    logic [SAMPLE_BITS-1:0] sample_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             fill_reg, fill_next;
    logic                   push;
    logic                   op_in;

    // Two-entry queue; accept while not full
    assign item.ready = (fill_reg != 2'd2);
    assign push       = item.valid && item.ready;

    // Classify the request
    assign op_in = item.cmd ? vctg_pkg::OP_SAMPLE : vctg_pkg::OP_TICK;

    assign head.valid  = (fill_reg != 2'd0);
    assign head.op     = op_reg[rd_ptr_reg];
    assign head_sample = sample_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]     <= op_in;
            sample_reg[wr_ptr_reg] <= item.sample;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vctg_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle
module vctg_div #(
    parameter int NUM_BITS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [NUM_BITS-1:0]           num,
    input  wire logic [vctg_pkg::DEN_BITS-1:0] den,
    output logic [NUM_BITS-1:0]                quot,
    output vctg_pkg::div_status_t              status
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    localparam int DB       = vctg_pkg::DEN_BITS;

    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [DB-1:0]       rem_reg, rem_next;
    logic [DB-1:0]       den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DB:0]         partial;
    logic [DB:0]         diff;
    logic                fits;

    // One shift-subtract step
    assign partial = {rem_reg, acc_reg[NUM_BITS-1]};
    assign fits    = (partial >= {1'b0, den_reg});
    assign diff    = partial - {1'b0, den_reg};

    always_comb
    begin
        rem_next = fits ? diff[DB-1:0] : partial[DB-1:0];
        acc_next = {acc_reg[NUM_BITS-2:0], fits};
    end

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign quot        = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/vctg_back.sv @@
`default_nettype none

module vctg_back #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire vctg_pkg::cfg_t           cfg,
    input  wire vctg_pkg::queue_head_t    head,
    input  wire logic [SAMPLE_BITS-1:0]   head_sample,
    output logic                          pop,
    vctg_result_if.source                 result
);

    localparam int PROD_BITS = SAMPLE_BITS + 10;
    localparam int NUM_BITS  = (PROD_BITS > 16) ? PROD_BITS : 16;
    localparam int CMP_BITS  = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
    localparam int DB        = vctg_pkg::DEN_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_FSET  = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [COUNT_BITS-1:0]  next_toggle_reg, next_toggle_next;
    logic                   speaker_on_reg, speaker_on_next;
    logic [15:0]            half_ticks_reg, half_ticks_next;
    logic [1:0]             pin_levels_reg, pin_levels_next;
    logic [9:0]             tone_freq_reg, tone_freq_next;
    logic [SAMPLE_BITS-1:0] diff_reg, diff_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_pins_reg;
    logic                   out_enabled_reg;
    logic [15:0]            out_half_reg;
    logic [9:0]             out_freq_reg;
    logic                   out_load;
    logic                   slot_free;

    logic [CMP_BITS-1:0]    sample_ext;
    logic [CMP_BITS-1:0]    thr_ext;
    logic [CMP_BITS-1:0]    diff_full;
    logic                   at_or_above;
    logic [COUNT_BITS-1:0]  tick_inc;
    logic                   toggle;
    logic [PROD_BITS-1:0]   product;
    logic [DB-1:0]          span_den;
    logic [NUM_BITS:0]      freq_sum;
    logic [9:0]             freq_sat;

    logic                   div_start;
    logic [NUM_BITS-1:0]    div_num;
    logic [DB-1:0]          div_den;
    logic [NUM_BITS-1:0]    div_quot;
    vctg_pkg::div_status_t  div_stat;

    vctg_div #(
        .NUM_BITS (NUM_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_stat)
    );

    // Output slot can take a new result
    assign slot_free = !out_valid_reg || result.ready;

    // Threshold compare
    assign sample_ext  = CMP_BITS'(head_sample);
    assign thr_ext     = CMP_BITS'(cfg.on_threshold);
    assign at_or_above = (sample_ext >= thr_ext);
    assign diff_full   = sample_ext - thr_ext;

    // Tick path
    assign tick_inc = tick_count_reg + COUNT_BITS'(1);
    assign toggle   = speaker_on_reg && (tick_inc >= next_toggle_reg);

    // Linear map: span * (sample - threshold), divided by the sample span
    assign product  = PROD_BITS'(cfg.freq_span) * PROD_BITS'(diff_reg);
    assign span_den = (cfg.sample_span == 10'd0) ? DB'(1) : DB'(cfg.sample_span);
    assign freq_sum = (NUM_BITS+1)'(div_quot) + (NUM_BITS+1)'(cfg.freq_offset);
    assign freq_sat = (freq_sum > (NUM_BITS+1)'(vctg_pkg::FREQ_MAX)) ?
                      vctg_pkg::FREQ_MAX : freq_sum[9:0];

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        tick_count_next  = tick_count_reg;
        next_toggle_next = next_toggle_reg;
        speaker_on_next  = speaker_on_reg;
        half_ticks_next  = half_ticks_reg;
        pin_levels_next  = pin_levels_reg;
        tone_freq_next   = tone_freq_reg;
        diff_next        = diff_reg;
        pop              = 1'b0;
        out_load         = 1'b0;
        div_start        = 1'b0;
        div_num          = NUM_BITS'(product);
        div_den          = span_den;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    pop = 1'b1;
                    if (head.op == vctg_pkg::OP_TICK)
                    begin
                        tick_count_next = tick_inc;
                        if (toggle)
                        begin
                            pin_levels_next  = pin_levels_reg ^ vctg_pkg::PINS_FLIP;
                            next_toggle_next = next_toggle_reg
                                               + COUNT_BITS'(half_ticks_reg);
                        end
                        out_load = 1'b1;
                    end
                    else if (at_or_above)
                    begin
                        diff_next  = diff_full[SAMPLE_BITS-1:0];
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        speaker_on_next = 1'b0;
                        tone_freq_next  = 10'd0;
                        half_ticks_next = vctg_pkg::at_least_one(cfg.idle_half_period);
                        out_load        = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                // divider captures the product
                div_start  = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    speaker_on_next = 1'b1;
                    tone_freq_next  = freq_sat;
                    state_next      = ST_FSET;
                end
            end
            ST_FSET:
            begin
                if (tone_freq_reg == 10'd0)
                begin
                    half_ticks_next = vctg_pkg::HALF_MAX;
                    state_next      = ST_WRITE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_BITS'(cfg.tick_rate);
                    div_den    = {tone_freq_reg, 1'b0};
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    half_ticks_next = vctg_pkg::at_least_one(div_quot[15:0]);
                    state_next      = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_count_reg  <= '0;
            next_toggle_reg <= COUNT_BITS'(vctg_pkg::RST_IDLE_HALF);
            speaker_on_reg  <= 1'b0;
            half_ticks_reg  <= vctg_pkg::RST_IDLE_HALF;
            pin_levels_reg  <= vctg_pkg::PINS_RESET;
            tone_freq_reg   <= 10'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tick_count_reg  <= tick_count_next;
            next_toggle_reg <= next_toggle_next;
            speaker_on_reg  <= speaker_on_next;
            half_ticks_reg  <= half_ticks_next;
            pin_levels_reg  <= pin_levels_next;
            tone_freq_reg   <= tone_freq_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        if (out_load)
        begin
            out_pins_reg    <= pin_levels_next;
            out_enabled_reg <= speaker_on_next;
            out_half_reg    <= half_ticks_next;
            out_freq_reg    <= tone_freq_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pins        = out_pins_reg;
    assign result.enabled     = out_enabled_reg;
    assign result.half_period = out_half_reg;
    assign result.frequency   = out_freq_reg;

    // Checks
    a_pins_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        pin_levels_reg[0] != pin_levels_reg[1])
        else $error("speaker pins not complementary");

    a_freq_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        !speaker_on_reg |-> (tone_freq_reg == 10'd0))
        else $error("frequency nonzero while tone disabled");

    a_half_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        half_ticks_reg != 16'd0)
        else $error("half period is zero");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider busy outside a divide wait");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/voltage_controlled_tone_generator_core.sv @@
// A tick or below-threshold sample passes the queue into the registered output slot;
// an enabling sample passes ST_MUL, ST_DIV1, ST_FSET, ST_DIV2 (skipped for a zero
// frequency) and ST_WRITE. Throughput: one tick per cycle while the output slot is
// free; an enabling sample holds the back end for one or two passes through the
// single shared one-bit-per-cycle divider. A two-entry queue keeps accepting requests
// while the back end works. Async active-low reset restores config and tone state.
`default_nettype none

module voltage_controlled_tone_generator_core #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vctg_item_if.sink     item,
    vctg_result_if.source result,
    vctg_cfg_if.sink      cfg
);

    vctg_pkg::cfg_t              cfg_reg, cfg_next;
    vctg_pkg::queue_head_t       head;
    logic [SAMPLE_BITS-1:0]      head_sample;
    logic                        pop;

    // Register file, always ready
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                vctg_pkg::CFG_ON_THRESHOLD: cfg_next.on_threshold     = cfg.data[9:0];
                vctg_pkg::CFG_FREQ_OFFSET:  cfg_next.freq_offset      = cfg.data[9:0];
                vctg_pkg::CFG_FREQ_SPAN:    cfg_next.freq_span        = cfg.data[9:0];
                vctg_pkg::CFG_SAMPLE_SPAN:  cfg_next.sample_span      = cfg.data[9:0];
                vctg_pkg::CFG_TICK_RATE:    cfg_next.tick_rate        = cfg.data;
                vctg_pkg::CFG_IDLE_HALF:    cfg_next.idle_half_period = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold     <= vctg_pkg::RST_ON_THRESHOLD;
            cfg_reg.freq_offset      <= vctg_pkg::RST_FREQ_OFFSET;
            cfg_reg.freq_span        <= vctg_pkg::RST_FREQ_SPAN;
            cfg_reg.sample_span      <= vctg_pkg::RST_SAMPLE_SPAN;
            cfg_reg.tick_rate        <= vctg_pkg::RST_TICK_RATE;
            cfg_reg.idle_half_period <= vctg_pkg::RST_IDLE_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify
    vctg_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .pop         (pop),
        .head        (head),
        .head_sample (head_sample)
    );

    // Back end: execute and hold the result
    vctg_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .head_sample (head_sample),
        .pop         (pop),
        .result      (result)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int SAMPLE_W      = 10;
    localparam int COUNT_W       = 32;
    localparam int PHASES        = 8;
    localparam int RAND_PER_PHASE = 180;
    // Longest block latency is for an enabling sample
    localparam int SETTLE_CYCLES = 50;
    localparam int LONG_STALL    = 200;
    // About 1500 requests, each with its time in the block plus sender gaps,
    // receiver stalls and the long hold-off, taken several times over
    localparam int LIMIT_CYCLES  = 600000;

    // Register indexes past the end of the map: writes must be ignored
    localparam logic [vctg_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [vctg_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
    } tone_req_t;

    typedef struct packed {
        logic [1:0]  pins;
        logic        enabled;
        logic [15:0] half_period;
        logic [9:0]  frequency;
    } tone_out_t;

    logic clk = 1'b0;
    logic rst_n;

    vctg_item_if #(.SAMPLE_BITS(SAMPLE_W)) item_bus ();
    vctg_result_if                         result_bus ();
    vctg_cfg_if                            cfg_bus ();

    voltage_controlled_tone_generator_core #(
        .SAMPLE_BITS(SAMPLE_W),
        .COUNT_BITS (COUNT_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .result(result_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and expectations
    tone_req_t   tone_requests[$];
    tone_out_t   tone_expect_q[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned cfg_writes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned long_stall_left = 0;
    logic        req_taken = 1'b0;

    // Predicted tone state and register copy
    vctg_pkg::cfg_t     tone_cfg;
    logic [COUNT_W-1:0] tick_count;
    logic [COUNT_W-1:0] next_toggle;
    logic               tone_on;
    logic [15:0]        half_ticks;
    logic [1:0]         pin_state;
    logic [9:0]         tone_freq;

    // Advance the tone state by one request and queue the result it shows
    function automatic void advance_tone(logic cmd, logic [SAMPLE_W-1:0] s);
        logic [31:0] prod;
        logic [31:0] divisor;
        logic [31:0] mapped;
        logic [31:0] half;
        logic [9:0]  freq;
        tone_out_t   res;
        if (cmd == vctg_pkg::OP_SAMPLE)
        begin
            if (s >= tone_cfg.on_threshold)
            begin
                prod    = 32'(tone_cfg.freq_span) * (32'(s) - 32'(tone_cfg.on_threshold));
                divisor = (tone_cfg.sample_span == 10'd0) ? 32'd1
                                                          : 32'(tone_cfg.sample_span);
                mapped  = prod / divisor + 32'(tone_cfg.freq_offset);
                freq    = (mapped > 32'(vctg_pkg::FREQ_MAX)) ? vctg_pkg::FREQ_MAX
                                                             : mapped[9:0];
                half    = (freq == 10'd0) ? 32'(vctg_pkg::HALF_MAX)
                                          : 32'(tone_cfg.tick_rate) / (32'd2 * 32'(freq));
                tone_on    = 1'b1;
                tone_freq  = freq;
                half_ticks = (half[15:0] == 16'd0) ? 16'd1 : half[15:0];
            end
            else
            begin
                tone_on    = 1'b0;
                tone_freq  = 10'd0;
                half_ticks = (tone_cfg.idle_half_period == 16'd0) ? 16'd1
                                                                  : tone_cfg.idle_half_period;
            end
        end
        else
        begin
            tick_count = tick_count + COUNT_W'(1);
            if (tone_on && tick_count >= next_toggle)
            begin
                pin_state   = pin_state ^ vctg_pkg::PINS_FLIP;
                next_toggle = next_toggle + COUNT_W'(half_ticks);
            end
        end
        res.pins        = pin_state;
        res.enabled     = tone_on;
        res.half_period = half_ticks;
        res.frequency   = tone_freq;
        tone_expect_q.push_back(res);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_req(logic cmd, logic [SAMPLE_W-1:0] s);
        tone_req_t r;
        r.cmd    = cmd;
        r.sample = s;
        tone_requests.push_back(r);
    endfunction

    // Mostly ticks; samples lean on the threshold and the field ends
    function automatic tone_req_t random_req();
        tone_req_t   r;
        int unsigned pick;
        int unsigned thr;
        int unsigned lo;
        int unsigned hi;
        thr      = 32'(tone_cfg.on_threshold);
        lo       = (thr < 3) ? 0 : thr - 3;
        hi       = (thr > 1020) ? 1023 : thr + 3;
        r.sample = SAMPLE_W'($urandom_range(0, 1023));
        r.cmd    = ($urandom_range(0, 99) < 15) ? vctg_pkg::OP_SAMPLE : vctg_pkg::OP_TICK;
        if (r.cmd == vctg_pkg::OP_SAMPLE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.sample = SAMPLE_W'($urandom_range(lo, hi));
            else if (pick < 45)
                r.sample = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            else if (pick < 65)
                r.sample = SAMPLE_W'($urandom_range(thr, 1023));
        end
        return r;
    endfunction

    // Register write over the config channel, one request at a time
    task automatic write_reg(logic [vctg_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [vctg_pkg::CFG_DATA_BITS-1:0] val);
        int unsigned seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do @(negedge clk);
        while (cfg_writes == seen);
        cfg_bus.valid <= 1'b0;
    endtask

    // Narrow registers get junk in the unused upper bits
    task automatic write_all(int unsigned thr, int unsigned off, int unsigned span,
                             int unsigned sspan, int unsigned rate, int unsigned idle);
        write_reg(vctg_pkg::CFG_ON_THRESHOLD, {6'($urandom), 10'(thr)});
        write_reg(vctg_pkg::CFG_FREQ_OFFSET,  {6'($urandom), 10'(off)});
        write_reg(vctg_pkg::CFG_FREQ_SPAN,    {6'($urandom), 10'(span)});
        write_reg(vctg_pkg::CFG_SAMPLE_SPAN,  {6'($urandom), 10'(sspan)});
        write_reg(vctg_pkg::CFG_TICK_RATE,    16'(rate));
        write_reg(vctg_pkg::CFG_IDLE_HALF,    16'(idle));
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    endtask

    // Checked at the rising edge, where the driver's last update has settled
    task automatic wait_drained();
        do @(posedge clk);
        while (tone_requests.size() != 0 || item_bus.valid || tone_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Request driver: hold valid until taken, then maybe idle
    always @(negedge clk)
    begin : req_driver
        logic      offer;
        tone_req_t nxt;
        if (rst_n && (!item_bus.valid || req_taken))
        begin
            offer = (tone_requests.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            if (offer)
            begin
                nxt = tone_requests.pop_front();
                item_bus.cmd    <= nxt.cmd;
                item_bus.sample <= nxt.sample;
            end
            item_bus.valid <= offer;
        end
    end

    // Result sink: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin : result_sink
        if (long_stall_left != 0)
        begin
            long_stall_left = long_stall_left - 1;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: track register writes, predict on accepted requests, check results
    always @(posedge clk)
    begin : bus_monitor
        tone_out_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("voltage_controlled_tone_generator_core verification failed");
            $finish;
        end
        else
        begin
            req_taken = item_bus.valid && item_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                unique case (cfg_bus.index)
                    vctg_pkg::CFG_ON_THRESHOLD: tone_cfg.on_threshold = cfg_bus.data[9:0];
                    vctg_pkg::CFG_FREQ_OFFSET:  tone_cfg.freq_offset  = cfg_bus.data[9:0];
                    vctg_pkg::CFG_FREQ_SPAN:    tone_cfg.freq_span    = cfg_bus.data[9:0];
                    vctg_pkg::CFG_SAMPLE_SPAN:  tone_cfg.sample_span  = cfg_bus.data[9:0];
                    vctg_pkg::CFG_TICK_RATE:    tone_cfg.tick_rate    = cfg_bus.data;
                    vctg_pkg::CFG_IDLE_HALF:    tone_cfg.idle_half_period = cfg_bus.data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (req_taken)
                advance_tone(item_bus.cmd, item_bus.sample);
            if (result_bus.valid && result_bus.ready)
            begin
                if (tone_expect_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = tone_expect_q.pop_front();
                    check_field("pins",        32'(want.pins),        32'(result_bus.pins));
                    check_field("enabled",     32'(want.enabled),     32'(result_bus.enabled));
                    check_field("half_period", 32'(want.half_period),
                                32'(result_bus.half_period));
                    check_field("frequency",   32'(want.frequency),
                                32'(result_bus.frequency));
                end
            end
        end
    end

    // Sequencer: reset, directed requests, then randomized phases
    initial
    begin : sequencer
        tone_req_t r;
        rst_n              = 1'b0;
        item_bus.valid     = 1'b0;
        item_bus.cmd       = vctg_pkg::OP_TICK;
        item_bus.sample    = '0;
        result_bus.ready   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = vctg_pkg::CFG_ON_THRESHOLD;
        cfg_bus.data       = '0;

        tone_cfg.on_threshold     = vctg_pkg::RST_ON_THRESHOLD;
        tone_cfg.freq_offset      = vctg_pkg::RST_FREQ_OFFSET;
        tone_cfg.freq_span        = vctg_pkg::RST_FREQ_SPAN;
        tone_cfg.sample_span      = vctg_pkg::RST_SAMPLE_SPAN;
        tone_cfg.tick_rate        = vctg_pkg::RST_TICK_RATE;
        tone_cfg.idle_half_period = vctg_pkg::RST_IDLE_HALF;
        tick_count  = '0;
        next_toggle = COUNT_W'(vctg_pkg::RST_IDLE_HALF);
        tone_on     = 1'b0;
        half_ticks  = vctg_pkg::RST_IDLE_HALF;
        pin_state   = vctg_pkg::PINS_RESET;
        tone_freq   = 10'd0;

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: below/at threshold, field ends, alternating bit patterns
        @(posedge clk);
        queue_req(vctg_pkg::OP_TICK,   10'h3FF);
        queue_req(vctg_pkg::OP_SAMPLE, 10'd0);
        queue_req(vctg_pkg::OP_SAMPLE, vctg_pkg::RST_ON_THRESHOLD - 10'd1);
        queue_req(vctg_pkg::OP_SAMPLE, vctg_pkg::RST_ON_THRESHOLD);
        repeat (3) queue_req(vctg_pkg::OP_TICK, 10'h000);
        queue_req(vctg_pkg::OP_SAMPLE, 10'h3FF);
        repeat (4) queue_req(vctg_pkg::OP_TICK, 10'h155);
        queue_req(vctg_pkg::OP_SAMPLE, 10'h2AA);
        queue_req(vctg_pkg::OP_SAMPLE, 10'h155);
        queue_req(vctg_pkg::OP_TICK,   10'h2AA);
        queue_req(vctg_pkg::OP_SAMPLE, 10'd0);
        repeat (2) queue_req(vctg_pkg::OP_TICK, 10'h000);
        queue_req(vctg_pkg::OP_SAMPLE, vctg_pkg::RST_ON_THRESHOLD);

        // Sink holds off while the driver keeps pushing
        long_stall_left = LONG_STALL;
        repeat (RAND_PER_PHASE)
        begin
            r = random_req();
            tone_requests.push_back(r);
        end
        wait_drained();

        for (int p = 1; p < PHASES; p++)
        begin
            unique case (p)
                1: write_all(0, 1023, 1023, 1, 65535, 65535);      // saturated frequency
                2: write_all(1023, 0, 0, 0, 1, 0);                 // zero frequency, zero idle
                3: write_all(100, 0, 5, 1000, 300, 1);             // frequency at most 4, zero below 300
                4: write_all(300, 200, 800, 0, 1, 7);              // zero span, half clamps to 1
                7: write_all(32'(vctg_pkg::RST_ON_THRESHOLD), 32'(vctg_pkg::RST_FREQ_OFFSET),
                             32'(vctg_pkg::RST_FREQ_SPAN), 32'(vctg_pkg::RST_SAMPLE_SPAN),
                             32'(vctg_pkg::RST_TICK_RATE), 32'(vctg_pkg::RST_IDLE_HALF));
                default: write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(1, 4000), $urandom_range(0, 65535));
            endcase
            @(posedge clk);
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 33; recv_stall_pct = 33;
                end
            endcase
            repeat (RAND_PER_PHASE)
            begin
                r = random_req();
                tone_requests.push_back(r);
            end
            wait_drained();
        end

        if (tone_expect_q.size() != 0)
        begin
            $error("%0d results never arrived", tone_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("voltage_controlled_tone_generator_core verification clean");
        else
            $display("voltage_controlled_tone_generator_core verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vctg_pkg.sv
rtl/vctg_if.sv
rtl/vctg_front.sv
rtl/vctg_div.sv
rtl/vctg_back.sv
rtl/voltage_controlled_tone_generator_core.sv
tb/sv/testbench.sv
